// File: rtl/core/button_and_rotary_encoder_qualifier_defines.svh
// ----------------------------------------------------------------------------
// Button and rotary encoder qualifier: assertion macros
// Shared property wrappers for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef BUTTON_AND_ROTARY_ENCODER_QUALIFIER_DEFINES_SVH
`define BUTTON_AND_ROTARY_ENCODER_QUALIFIER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BREQ_ASSERT_NOW(LABEL, CLK, RST_N, ANTE, CONS, MSG) \
    LABEL: assert property (@(posedge CLK) disable iff (!RST_N) (ANTE) |-> (CONS)) \
        else $error(MSG);

// Next-cycle implication, disabled while reset is asserted.
`define BREQ_ASSERT_NEXT(LABEL, CLK, RST_N, ANTE, CONS, MSG) \
    LABEL: assert property (@(posedge CLK) disable iff (!RST_N) (ANTE) |=> (CONS)) \
        else $error(MSG);

`endif

// File: rtl/core/breq_pkg.sv
// ----------------------------------------------------------------------------
// Button and rotary encoder qualifier package
// Register map, reset values and shared types.
// ----------------------------------------------------------------------------
package breq_pkg;

    // Configuration register indexes (word address paddr[3:2]).
    typedef enum logic [1:0] {
        REG_BUTTON_LOCKOUT = 2'd0,
        REG_PUSH_LOCKOUT   = 2'd1,
        REG_STEP_LOCKOUT   = 2'd2,
        REG_ACTIVE_LOW     = 2'd3
    } reg_index_t;

    localparam int ADDR_BITS    = 4;
    localparam int DATA_BITS    = 32;
    localparam int LOCKOUT_BITS = 16;

    // Reset values of the configuration registers.
    localparam logic [LOCKOUT_BITS-1:0] BUTTON_LOCKOUT_RESET = 16'd180;
    localparam logic [LOCKOUT_BITS-1:0] PUSH_LOCKOUT_RESET   = 16'd180;
    localparam logic [LOCKOUT_BITS-1:0] STEP_LOCKOUT_RESET   = 16'd35;
    localparam logic                    ACTIVE_LOW_RESET     = 1'b1;

    // Raw line levels of one poll sample.
    typedef struct packed {
        logic home;
        logic back;
        logic push;
        logic enc_clock;
        logic enc_data;
    } levels_t;

    // One qualified result beat.
    typedef struct packed {
        logic home_event;
        logic back_event;
        logic push_event;
        logic step_cw;
        logic step_ccw;
    } events_t;

endpackage

// File: rtl/core/button_and_rotary_encoder_qualifier.sv
// ----------------------------------------------------------------------------
// Button and rotary encoder qualifier
// Turns raw poll samples of three buttons and an encoder into qualified
// press pulses and rotation steps with lockout times; home and back share one.
// ----------------------------------------------------------------------------
// Usage: every accepted sample beat yields exactly one result beat. A sample
// is captured in an input register and then qualified into the result
// register, from which its result beat is taken. The block sustains one
// sample per clock while the result channel is not stalled. The rate is
// set by the single qualification stage, whose press/step state is updated
// in the same cycle it is read. in_stall only rises when the result register
// is full and stalled. Lockout times compare (now - last accept) modulo
// 2^TIME_BITS as unsigned.
// Configuration writes must be made while no sample is in flight.
// ----------------------------------------------------------------------------
`include "button_and_rotary_encoder_qualifier_defines.svh"

module button_and_rotary_encoder_qualifier
    import breq_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    // Configuration port.
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,

    // Sample input channel.
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 home_level,
    input  logic                 back_level,
    input  logic                 push_level,
    input  logic                 enc_clock_level,
    input  logic                 enc_data_level,
    input  logic [31:0]          now_ms,

    // Result output channel.
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 home_event,
    output logic                 back_event,
    output logic                 push_event,
    output logic                 step_cw,
    output logic                 step_ccw
);

    // Configuration registers.
    logic [LOCKOUT_BITS-1:0] button_lockout_reg;
    logic [LOCKOUT_BITS-1:0] push_lockout_reg;
    logic [LOCKOUT_BITS-1:0] step_lockout_reg;
    logic                    active_low_reg;
    logic                    cfg_write;
    reg_index_t              cfg_index;

    // Input register.
    logic                    in_valid_reg;
    levels_t                 in_levels_reg;
    logic [TIME_BITS-1:0]    in_now_reg;

    // Qualifier state.
    logic                    home_was_reg;
    logic                    back_was_reg;
    logic                    push_was_reg;
    logic                    last_clock_reg;
    logic [TIME_BITS-1:0]    home_time_reg;
    logic [TIME_BITS-1:0]    back_time_reg;
    logic [TIME_BITS-1:0]    push_time_reg;
    logic [TIME_BITS-1:0]    step_time_reg;

    // Result register.
    logic                    out_valid_reg;
    events_t                 out_events_reg;

    // Stage control and combinational results.
    logic                    advance;
    logic                    work;
    logic                    home_pressed;
    logic                    back_pressed;
    logic                    push_pressed;
    logic                    home_hit;
    logic                    back_hit;
    logic                    push_hit;
    logic                    step_hit;
    events_t                 events_next;

    // Elapsed time since an accept time, at least the lockout.
    function automatic logic elapsed_ok(
        input logic [TIME_BITS-1:0]    now,
        input logic [TIME_BITS-1:0]    since,
        input logic [LOCKOUT_BITS-1:0] lockout
    );
        logic [TIME_BITS-1:0] diff;
        diff = now - since;
        return diff >= TIME_BITS'(lockout);
    endfunction

    // Configuration write decode and read back.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = reg_index_t'(paddr[3:2]);

    always_comb
    begin
        unique case (cfg_index)
            REG_BUTTON_LOCKOUT: prdata = DATA_BITS'(button_lockout_reg);
            REG_PUSH_LOCKOUT:   prdata = DATA_BITS'(push_lockout_reg);
            REG_STEP_LOCKOUT:   prdata = DATA_BITS'(step_lockout_reg);
            REG_ACTIVE_LOW:     prdata = DATA_BITS'(active_low_reg);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            button_lockout_reg <= BUTTON_LOCKOUT_RESET;
            push_lockout_reg   <= PUSH_LOCKOUT_RESET;
            step_lockout_reg   <= STEP_LOCKOUT_RESET;
            active_low_reg     <= ACTIVE_LOW_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BUTTON_LOCKOUT: button_lockout_reg <= pwdata[LOCKOUT_BITS-1:0];
                REG_PUSH_LOCKOUT:   push_lockout_reg   <= pwdata[LOCKOUT_BITS-1:0];
                REG_STEP_LOCKOUT:   step_lockout_reg   <= pwdata[LOCKOUT_BITS-1:0];
                REG_ACTIVE_LOW:     active_low_reg     <= pwdata[0];
                default:            ;
            endcase
        end
    end

    // Handshake: the input register moves on whenever the result register
    // is empty or its beat is being taken.
    assign advance  = !out_valid_reg || !out_stall;
    assign work     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_levels_reg <= '{home:      home_level,
                               back:      back_level,
                               push:      push_level,
                               enc_clock: enc_clock_level,
                               enc_data:  enc_data_level};
            in_now_reg    <= TIME_BITS'(now_ms);
        end
    end

    // Press detection and lockout qualification.
    assign home_pressed = in_levels_reg.home ^ active_low_reg;
    assign back_pressed = in_levels_reg.back ^ active_low_reg;
    assign push_pressed = in_levels_reg.push ^ active_low_reg;

    assign home_hit = home_pressed && !home_was_reg
                      && elapsed_ok(in_now_reg, home_time_reg, button_lockout_reg);
    assign back_hit = back_pressed && !back_was_reg
                      && elapsed_ok(in_now_reg, back_time_reg, button_lockout_reg);
    assign push_hit = push_pressed && !push_was_reg
                      && elapsed_ok(in_now_reg, push_time_reg, push_lockout_reg);
    assign step_hit = last_clock_reg && !in_levels_reg.enc_clock
                      && elapsed_ok(in_now_reg, step_time_reg, step_lockout_reg);

    assign events_next = '{home_event: home_hit,
                           back_event: back_hit,
                           push_event: push_hit,
                           step_cw:    step_hit && in_levels_reg.enc_data,
                           step_ccw:   step_hit && !in_levels_reg.enc_data};

    // Qualifier state follows every processed sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            home_was_reg   <= 1'b0;
            back_was_reg   <= 1'b0;
            push_was_reg   <= 1'b0;
            last_clock_reg <= 1'b1;
            home_time_reg  <= '0;
            back_time_reg  <= '0;
            push_time_reg  <= '0;
            step_time_reg  <= '0;
        end
        else if (work)
        begin
            home_was_reg   <= home_pressed;
            back_was_reg   <= back_pressed;
            push_was_reg   <= push_pressed;
            last_clock_reg <= in_levels_reg.enc_clock;
            if (home_hit)
            begin
                home_time_reg <= in_now_reg;
            end
            if (back_hit)
            begin
                back_time_reg <= in_now_reg;
            end
            if (push_hit)
            begin
                push_time_reg <= in_now_reg;
            end
            if (step_hit)
            begin
                step_time_reg <= in_now_reg;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (work)
        begin
            out_events_reg <= events_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign home_event = out_events_reg.home_event;
    assign back_event = out_events_reg.back_event;
    assign push_event = out_events_reg.push_event;
    assign step_cw    = out_events_reg.step_cw;
    assign step_ccw   = out_events_reg.step_ccw;

    // Checks on the qualifier logic.
    `BREQ_ASSERT_NOW(a_step_exclusive, clk, rst_n, out_valid_reg,
        !(out_events_reg.step_cw && out_events_reg.step_ccw),
        "Clockwise and counter-clockwise step in one beat.")
    `BREQ_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, in_stall,
        in_valid_reg && out_valid_reg && out_stall,
        "Input stalled without a stalled result held.")
    `BREQ_ASSERT_NEXT(a_home_time, clk, rst_n, work && home_hit,
        home_time_reg == $past(in_now_reg) && out_events_reg.home_event,
        "Home press accepted without recording its time.")
    `BREQ_ASSERT_NEXT(a_push_held, clk, rst_n, work && push_hit,
        push_was_reg && out_valid_reg,
        "Push press accepted without marking the button held.")

endmodule
